>>> rtl/core/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 5;

  typedef enum logic [2:0] {
    CmdPushFront = 3'd0,
    CmdPushRear  = 3'd1,
    CmdPopFront  = 3'd2,
    CmdPopRear   = 3'd3,
    CmdDump      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  typedef enum logic {
    StateIdle = 1'b0,
    StateDump = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [DataW-1:0] value;
  } cdq_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [1:0]              status;
    logic [CntW-1:0]         count;
    logic                    last;
  } cdq_res_t;

endpackage
`default_nettype wire

>>> rtl/core/cdq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/circular_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed 32-bit words kept in a circular RAM.
// ----------------------------------------------------------------------------
// Push front, push rear, pop front and pop rear leave busy low, so while busy
// is low a new command can be started every cycle; its single result
// appears on res_o, strobed by res_valid_o, in the cycle after the start. A
// dump of N held elements streams N results, front first, one RAM read per
// cycle; busy is high while the elements after the first are read and the
// final result carries last. Pops and dumps of an empty deque give one underflow
// result, a push into a full deque gives one overflow result, and unused
// command codes are dropped without a result. Results cannot be held off by
// the receiver, so they must be taken in the cycle they are strobed.
module circular_deque_unit
  import cdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire cdq_req_t req_i,
  output logic          res_valid_o,
  output cdq_res_t      res_o
);

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    return (i == IdxW'(Depth - 1)) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(Depth - 1) : i - IdxW'(1);
  endfunction

  state_e            state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   occ_q, occ_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   rem_q, rem_d;

  logic              valid_q, valid_d;
  logic              sel_rd_q, sel_rd_d;
  logic [1:0]        status_q, status_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              last_q, last_d;

  logic              accept;
  logic              full, empty;
  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  logic [DataW-1:0]  rdata;

  assign accept = start && !busy;
  assign full   = (occ_q == CntW'(Depth));
  assign empty  = (occ_q == '0);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    valid_d  = 1'b0;
    sel_rd_d = 1'b0;
    status_d = StOk;
    count_d  = occ_q;
    last_d   = 1'b1;
    we       = 1'b0;
    waddr    = tail_q;
    raddr    = head_q;
    busy     = 1'b0;

    case (state_q)
      StateIdle: begin
        if (accept) begin
          case (req_i.cmd)
            CmdPushFront, CmdPushRear: begin
              valid_d = 1'b1;
              if (full) begin
                status_d = StOverflow;
              end else begin
                we = 1'b1;
                if (req_i.cmd == CmdPushFront) begin
                  waddr  = idx_dec(head_q);
                  head_d = idx_dec(head_q);
                end else begin
                  waddr  = tail_q;
                  tail_d = idx_inc(tail_q);
                end
                occ_d   = occ_q + CntW'(1);
                count_d = occ_q + CntW'(1);
              end
            end
            CmdPopFront, CmdPopRear: begin
              valid_d = 1'b1;
              if (empty) begin
                status_d = StUnderflow;
              end else begin
                sel_rd_d = 1'b1;
                if (req_i.cmd == CmdPopFront) begin
                  raddr  = head_q;
                  head_d = idx_inc(head_q);
                end else begin
                  raddr  = idx_dec(tail_q);
                  tail_d = idx_dec(tail_q);
                end
                occ_d   = occ_q - CntW'(1);
                count_d = occ_q - CntW'(1);
              end
            end
            CmdDump: begin
              valid_d = 1'b1;
              if (empty) begin
                status_d = StUnderflow;
              end else begin
                sel_rd_d = 1'b1;
                raddr    = head_q;
                last_d   = (occ_q == CntW'(1));
                ptr_d    = idx_inc(head_q);
                rem_d    = occ_q - CntW'(1);
                if (occ_q != CntW'(1)) begin
                  state_d = StateDump;
                end
              end
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      StateDump: begin
        // stream the remaining elements, one read per cycle
        busy     = 1'b1;
        valid_d  = 1'b1;
        sel_rd_d = 1'b1;
        raddr    = ptr_q;
        last_d   = (rem_q == CntW'(1));
        ptr_d    = idx_inc(ptr_q);
        rem_d    = rem_q - CntW'(1);
        if (rem_q == CntW'(1)) begin
          state_d = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      ptr_q   <= '0;
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      ptr_q   <= ptr_d;
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_rd_q <= sel_rd_d;
    status_q <= status_d;
    count_q  <= count_d;
    last_q   <= last_d;
  end

  cdq_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read data lands in the cycle after its address, together with the beat
  assign res_valid_o   = valid_q;
  assign res_o.data    = sel_rd_q ? $signed(rdata) : '0;
  assign res_o.status  = status_q;
  assign res_o.count   = count_q;
  assign res_o.last    = last_q;

`ifndef SYNTHESIS
  a_dump_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o)
    else $error("dump stream has a gap");

  a_cmd_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == CmdPushFront || req_i.cmd == CmdPushRear ||
      req_i.cmd == CmdPopFront || req_i.cmd == CmdPopRear || req_i.cmd == CmdDump))
    |=> res_valid_o)
    else $error("accepted command gave no result");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == StOverflow) |-> (res_o.count == CntW'(Depth)))
    else $error("overflow reported while not full");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy)
    else $error("non-final beat with no dump in progress");
`endif

endmodule
`default_nettype wire
